### rtl/vdi_pkg.sv
// shared types, constants and controller codes for the vertex dedup indexer
package vdi_pkg;

	localparam int ENTRIES_DEF = 256;
	localparam int WORD_W      = 32;
	localparam int WORDS       = 8;
	localparam int KEY_W       = WORD_W * WORDS;
	localparam int INDEX_W     = 8;

	typedef struct packed {
		logic              first_of_mesh;
		logic [WORD_W-1:0] pos_x;
		logic [WORD_W-1:0] pos_y;
		logic [WORD_W-1:0] pos_z;
		logic [WORD_W-1:0] tex_u;
		logic [WORD_W-1:0] tex_v;
		logic [WORD_W-1:0] norm_x;
		logic [WORD_W-1:0] norm_y;
		logic [WORD_W-1:0] norm_z;
	} in_t;

	typedef struct packed {
		logic [INDEX_W-1:0] out_index;
		logic               is_new;
		logic               overflow;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic finish;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic scan_end;
		logic out_free;
	} sts_t;

endpackage

### rtl/vertex_dedup_indexer.sv
// top level of the vertex dedup indexer: controller and datapath
// One vertex is handled at a time. After a transfer in, the vertex is compared
// against the stored unique vertices of the current mesh, one entry per cycle
// through the single read port of the table memory, and the next vertex is taken
// only after the scan ends and the result has moved on; a match ends the scan early.
// The result sits in an output register, so the next vertex can be taken while it
// waits. A first-of-mesh mark resets the fill count only; no clearing pass is needed
// after reset.
module vertex_dedup_indexer #(
	parameter int ENTRIES = vdi_pkg::ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  vdi_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output vdi_pkg::out_t out_data
);

	vdi_pkg::cmd_t cmd;
	vdi_pkg::sts_t sts;

	vdi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	vdi_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### rtl/vdi_ctrl.sv
// controller state machine: accept, table scan, result hand-off
module vdi_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  vdi_pkg::sts_t sts,
	output vdi_pkg::cmd_t cmd
);

	vdi_pkg::state_t state_q;
	vdi_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vdi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			vdi_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = vdi_pkg::ST_SCAN;
				end
			end
			vdi_pkg::ST_SCAN: begin
				if (sts.hit || sts.scan_end) begin
					cmd.finish = 1'b1;
					state_d    = vdi_pkg::ST_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			vdi_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = vdi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vdi_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/vdi_dpath.sv
// datapath: key register, vertex table memory, scan pointer, compare and output register
module vdi_dpath #(
	parameter int ENTRIES = vdi_pkg::ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  vdi_pkg::in_t  in_data,
	input  vdi_pkg::cmd_t cmd,
	output vdi_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_stall,
	output vdi_pkg::out_t out_data
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	logic [vdi_pkg::KEY_W-1:0] mem [ENTRIES];

	logic [vdi_pkg::KEY_W-1:0] key_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             rd_ptr_q;
	logic                      rd_vld_s1;
	logic [AW-1:0]             rd_idx_s1;
	logic [vdi_pkg::KEY_W-1:0] rd_data_s1;
	vdi_pkg::out_t             res_q;
	vdi_pkg::out_t             out_q;
	logic                      out_valid_q;

	logic pending;
	logic issue;
	logic full;
	logic hit;
	logic append;

	assign pending = rd_ptr_q < cnt_q;
	assign issue   = cmd.scan && pending;
	assign full    = cnt_q == CW'(ENTRIES);
	assign hit     = rd_vld_s1 && (rd_data_s1 == key_q);
	assign append  = cmd.finish && !hit && !full;

	assign sts.hit      = hit;
	assign sts.scan_end = !rd_vld_s1 && !pending;
	assign sts.out_free = !out_valid_q || !out_stall;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_ptr_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				rd_ptr_q <= '0;
				if (in_data.first_of_mesh) begin
					cnt_q <= '0;
				end
			end else if (issue) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
			if (append) begin
				cnt_q <= cnt_q + CW'(1);
			end
			rd_vld_s1 <= issue;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// vertex table
	always_ff @(posedge clk) begin
		if (append) begin
			mem[cnt_q[AW-1:0]] <= key_q;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_ptr_q[AW-1:0]];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= {in_data.pos_x, in_data.pos_y, in_data.pos_z,
				in_data.tex_u, in_data.tex_v,
				in_data.norm_x, in_data.norm_y, in_data.norm_z};
		end
		if (issue) begin
			rd_idx_s1 <= rd_ptr_q[AW-1:0];
		end
		if (cmd.finish) begin
			if (hit) begin
				res_q.out_index <= vdi_pkg::INDEX_W'(rd_idx_s1);
				res_q.is_new    <= 1'b0;
				res_q.overflow  <= 1'b0;
			end else if (full) begin
				res_q.out_index <= '0;
				res_q.is_new    <= 1'b0;
				res_q.overflow  <= 1'b1;
			end else begin
				res_q.out_index <= vdi_pkg::INDEX_W'(cnt_q);
				res_q.is_new    <= 1'b1;
				res_q.overflow  <= 1'b0;
			end
		end
		if (cmd.emit) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/vdi_checker.sv
// port-level checks for the vertex dedup indexer, bound to the top level
module vdi_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input vdi_pkg::out_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a new entry and an overflow never come together
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.is_new && out_data.overflow))
		else $error("is_new and overflow both set");

	// overflow carries index zero
	a_ovf_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflow |-> out_data.out_index == '0)
		else $error("overflow with non-zero index");

	// one vertex at a time: input stalls right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a vertex is in work");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

### tb/sv/tb_top.sv
// self-checking testbench for the vertex dedup indexer: queued vertex driver, result monitor
`timescale 1ns / 1ps

module tb_top;

	localparam int ENTRIES       = vdi_pkg::ENTRIES_DEF;
	localparam int RANDOM_ITEMS  = 1400;
	localparam int MAX_IDLE      = 40;
	localparam int MAX_STALL     = 40;
	localparam int REPORT_LIMIT  = 10;

	localparam logic [vdi_pkg::WORD_W-1:0] POS_ZERO = 32'h0000_0000;
	localparam logic [vdi_pkg::WORD_W-1:0] NEG_ZERO = 32'h8000_0000;
	localparam logic [vdi_pkg::WORD_W-1:0] QNAN     = 32'h7fc0_0000;
	localparam logic [vdi_pkg::WORD_W-1:0] POS_INF  = 32'h7f80_0000;
	localparam logic [vdi_pkg::WORD_W-1:0] NEG_INF  = 32'hff80_0000;
	localparam logic [vdi_pkg::WORD_W-1:0] ALL_ONES = 32'hffff_ffff;
	localparam logic [vdi_pkg::WORD_W-1:0] ONE      = 32'h3f80_0000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	vdi_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	vdi_pkg::out_t out_data;

	vertex_dedup_indexer #(
		.ENTRIES(ENTRIES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	vdi_pkg::in_t  pending_vertices [$];
	vdi_pkg::out_t awaited_lookups [$];

	logic [vdi_pkg::KEY_W-1:0] mesh_table [ENTRIES];
	int unsigned               mesh_fill = 0;

	int unsigned     vertex_total = 0;
	int unsigned     vertices_accepted = 0;
	int unsigned     mismatches = 0;
	int unsigned     send_hold = 0;
	int unsigned     send_quiet_pct = 100;
	int unsigned     stall_hold = 0;
	int unsigned     stall_quiet_pct = 100;
	longint unsigned cycle_count = 0;
	longint unsigned cycle_limit = 64'd4_000_000;
	vdi_pkg::out_t   want;

	// expected index for one vertex, updating the mesh table
	function automatic vdi_pkg::out_t lookup_vertex(vdi_pkg::in_t v);
		logic [vdi_pkg::KEY_W-1:0] key;
		vdi_pkg::out_t             r;
		bit                        hit;
		int unsigned               i;
		key = {v.pos_x, v.pos_y, v.pos_z, v.tex_u, v.tex_v,
			v.norm_x, v.norm_y, v.norm_z};
		r   = '0;
		hit = 1'b0;
		if (v.first_of_mesh)
			mesh_fill = 0;
		for (i = 0; i < mesh_fill && !hit; i++) begin
			if (mesh_table[i] == key) begin
				r.out_index = vdi_pkg::INDEX_W'(i);
				hit = 1'b1;
			end
		end
		if (!hit) begin
			if (mesh_fill >= ENTRIES) begin
				r.overflow = 1'b1;
			end else begin
				mesh_table[mesh_fill] = key;
				r.out_index = vdi_pkg::INDEX_W'(mesh_fill);
				r.is_new = 1'b1;
				mesh_fill++;
			end
		end
		return r;
	endfunction

	function automatic void queue_vertex(vdi_pkg::in_t v);
		pending_vertices.insert(pending_vertices.size(), v);
	endfunction

	function automatic logic [vdi_pkg::WORD_W-1:0] random_word();
		case ($urandom_range(0, 11))
			0: return POS_ZERO;
			1: return NEG_ZERO;
			2: return QNAN | vdi_pkg::WORD_W'($urandom_range(0, 3));
			3: return POS_INF;
			4: return NEG_INF;
			5: return ALL_ONES;
			6: return ONE ^ vdi_pkg::WORD_W'($urandom_range(0, 1));
			default: return $urandom();
		endcase
	endfunction

	function automatic vdi_pkg::in_t random_vertex();
		vdi_pkg::in_t v;
		v.first_of_mesh = 1'b0;
		v.pos_x  = random_word();
		v.pos_y  = random_word();
		v.pos_z  = random_word();
		v.tex_u  = random_word();
		v.tex_v  = random_word();
		v.norm_x = random_word();
		v.norm_y = random_word();
		v.norm_z = random_word();
		return v;
	endfunction

	function automatic vdi_pkg::in_t uniform_vertex(logic fom, logic [vdi_pkg::WORD_W-1:0] w);
		vdi_pkg::in_t v;
		v = {fom, {vdi_pkg::WORDS{w}}};
		return v;
	endfunction

	// mostly short idles, a few long ones; none at all for quiet_pct of the draws
	function automatic int unsigned pick_idle(int unsigned quiet_pct, int unsigned longest);
		int unsigned r;
		if ($urandom_range(0, 99) < quiet_pct)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $urandom_range(1, 3);
		else if (r < 19)
			return $urandom_range(4, 10);
		return $urandom_range(11, longest);
	endfunction

	function automatic int unsigned pick_quiet();
		case ($urandom_range(0, 2))
			0: return 100;
			1: return 60;
			default: return 20;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				awaited_lookups.insert(awaited_lookups.size(), lookup_vertex(in_data));
				vertices_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (send_hold != 0 || pending_vertices.size() == 0) begin
					in_valid <= 1'b0;
					if (send_hold != 0)
						send_hold--;
				end else begin
					in_valid <= 1'b1;
					in_data  <= pending_vertices.pop_front();
					if ($urandom_range(0, 49) == 0)
						send_quiet_pct = pick_quiet();
					send_hold = pick_idle(send_quiet_pct, MAX_IDLE);
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_lookups.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: result with nothing pending: %s %0d new %0b overflow %0b",
							$time, "index", out_data.out_index, out_data.is_new,
							out_data.overflow);
				end else begin
					want = awaited_lookups.pop_front();
					if (out_data.out_index !== want.out_index ||
					    out_data.is_new !== want.is_new ||
					    out_data.overflow !== want.overflow) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"%0t: mismatch: expected index %0d new %0b overflow %0b,",
								" got index %0d new %0b overflow %0b"},
								$time, want.out_index, want.is_new, want.overflow,
								out_data.out_index, out_data.is_new, out_data.overflow);
					end
				end
			end
			if ($urandom_range(0, 199) == 0)
				stall_quiet_pct = pick_quiet();
			if (stall_hold != 0) begin
				out_stall <= 1'b1;
				stall_hold--;
			end else begin
				stall_hold = pick_idle(stall_quiet_pct, MAX_STALL);
				if (stall_hold != 0) begin
					out_stall <= 1'b1;
					stall_hold--;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= cycle_limit) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		vdi_pkg::in_t v;
		vdi_pkg::in_t mesh_pool [$];
		vdi_pkg::in_t prior_pool [$];
		int unsigned  random_items;
		int unsigned  mesh_no;
		int unsigned  mesh_len;
		int unsigned  k;
		int unsigned  pick;
		bit           long_mesh;

		// directed: bit-exact compare, signed zeros, nan payloads, mesh clears
		queue_vertex(uniform_vertex(1'b1, POS_ZERO));
		queue_vertex(uniform_vertex(1'b0, POS_ZERO));
		queue_vertex(uniform_vertex(1'b0, ALL_ONES));
		v = uniform_vertex(1'b0, POS_ZERO);
		v.pos_x = NEG_ZERO;
		queue_vertex(v);
		queue_vertex(v);
		v.norm_z = NEG_ZERO;
		queue_vertex(v);
		queue_vertex(uniform_vertex(1'b0, QNAN));
		queue_vertex(uniform_vertex(1'b0, QNAN | 32'h1));
		queue_vertex(uniform_vertex(1'b0, QNAN));
		queue_vertex(uniform_vertex(1'b0, POS_INF));
		queue_vertex(uniform_vertex(1'b0, NEG_INF));
		queue_vertex(uniform_vertex(1'b0, 32'haaaa_aaaa));
		queue_vertex(uniform_vertex(1'b0, 32'h5555_5555));
		v = '{1'b0, ONE, 32'h4000_0000, 32'hc040_0000, 32'h3f00_0000, 32'h3e80_0000,
			POS_ZERO, ONE, NEG_ZERO};
		queue_vertex(v);
		v.tex_v = 32'h3e80_0001;
		queue_vertex(v);
		queue_vertex(uniform_vertex(1'b0, ALL_ONES));
		queue_vertex(uniform_vertex(1'b1, ALL_ONES));
		queue_vertex(uniform_vertex(1'b0, POS_ZERO));
		queue_vertex(uniform_vertex(1'b1, POS_ZERO));
		queue_vertex(uniform_vertex(1'b1, POS_ZERO));

		// random meshes: short ones with heavy reuse, a few that overfill the table
		random_items = 0;
		mesh_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			long_mesh = (mesh_no == 2 || mesh_no == 17 || $urandom_range(0, 59) == 0);
			mesh_len = long_mesh ? $urandom_range(ENTRIES + 30, ENTRIES + 60) :
				$urandom_range(1, 40);
			prior_pool = mesh_pool;
			mesh_pool.delete();
			for (k = 0; k < mesh_len; k++) begin
				pick = $urandom_range(0, 99);
				if (mesh_pool.size() != 0 && pick < (long_mesh ? 6 : 45)) begin
					v = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
				end else if (mesh_pool.size() != 0 && pick < (long_mesh ? 8 : 60)) begin
					v = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
					v[$urandom_range(0, vdi_pkg::KEY_W - 1)] ^= 1'b1;
					mesh_pool.insert(mesh_pool.size(), v);
				end else if (prior_pool.size() != 0 && pick < (long_mesh ? 10 : 70)) begin
					v = prior_pool[$urandom_range(0, prior_pool.size() - 1)];
					mesh_pool.insert(mesh_pool.size(), v);
				end else begin
					v = random_vertex();
					mesh_pool.insert(mesh_pool.size(), v);
				end
				v.first_of_mesh = (k == 0);
				if (!long_mesh && k != 0 && $urandom_range(0, 49) == 0)
					v.first_of_mesh = 1'b1;
				queue_vertex(v);
			end
			mesh_no++;
			random_items += mesh_len;
		end

		vertex_total = pending_vertices.size();
		cycle_limit = longint'(vertex_total) * (ENTRIES + 8 + MAX_IDLE + MAX_STALL) * 3 + 10000;

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (vertices_accepted < vertex_total)
			@(posedge clk);
		while (awaited_lookups.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);

		if (mismatches == 0 && awaited_lookups.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### vertex_dedup_indexer.f
rtl/vdi_pkg.sv
rtl/vdi_ctrl.sv
rtl/vdi_dpath.sv
rtl/vertex_dedup_indexer.sv
rtl/vdi_checker.sv
tb/sv/tb_top.sv
